// ===== hw/rtl/mlts_pkg.sv =====
`default_nettype none

package mlts_pkg;

    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_LOAD  = 3'd1;
    localparam logic [2:0] MODE_CLEAR = 3'd2;
    localparam logic [2:0] MODE_SPEED = 3'd3;
    localparam logic [2:0] MODE_DIR   = 3'd4;
    localparam logic [2:0] MODE_COLOR = 3'd5;

    localparam logic [15:0] DEFAULT_COLOR_RESET = 16'hFFFF;
    localparam logic [1:0]  INTERVAL_RESET      = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMD,
        ST_TICK
    } state_t;

    typedef struct packed {
        logic               active;
        logic               direction;
        logic [1:0]         interval;
        logic [1:0]         counter;
        logic signed [12:0] x;
        logic [11:0]        width;
        logic [15:0]        color;
    } rec_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic        in_range;
        logic [11:0] text_width;
        logic [7:0]  speed;
        logic        direction;
        logic [15:0] color;
    } cmd_t;

    function automatic logic [1:0] speed_to_interval(input logic [7:0] speed);
        logic [1:0] iv;
        if (speed == 8'd1) iv = 2'd3;
        else if (speed == 8'd3) iv = 2'd1;
        else iv = 2'd2;
        return iv;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mlts_in_if.sv =====
`default_nettype none

interface mlts_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [4:0]  line;
    logic [11:0] text_width;
    logic [7:0]  speed;
    logic        direction;
    logic [15:0] color;

    modport source (
        output valid, mode, line, text_width, speed, direction, color,
        input  ready
    );

    modport sink (
        input  valid, mode, line, text_width, speed, direction, color,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/mlts_out_if.sv =====
`default_nettype none

interface mlts_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         line_index;
    logic               active;
    logic signed [12:0] x_position;
    logic               visible;
    logic [15:0]        line_color;
    logic               last;

    modport source (
        output valid, line_index, active, x_position, visible, line_color, last,
        input  ready
    );

    modport sink (
        input  valid, line_index, active, x_position, visible, line_color, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/multi_line_text_scroll_engine_unit.sv =====
// Scrolling text line table. A command word (load, clear, set speed, set direction,
// set color) is taken while idle and applied in the next cycle by the shared line
// update unit. A frame tick word walks the table one line per cycle through that same
// unit, advancing the line and loading its report into the output register; the walk
// holds on any cycle in which the previous report is still waiting to be taken.
// The input is ready only while the sequencer is idle, but a pending report does not
// block commands. default_color is written through cfg_we/cfg_wdata.
`default_nettype none

module multi_line_text_scroll_engine_unit
    import mlts_pkg::*;
#(
    parameter int LINES       = 4,
    parameter int PANEL_WIDTH = 64
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cfg_we,
    input  wire [15:0]       cfg_wdata,
    mlts_in_if.sink          items,
    mlts_out_if.source       results
);

    localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINES - 1);
    localparam logic signed [12:0] PW13 = 13'(PANEL_WIDTH);

    state_t              state_reg, state_next;
    cmd_t                cmd_reg;
    logic [IDX_W-1:0]    idx_reg;
    rec_t                lines_reg [LINES];
    logic [15:0]         default_color_reg;

    logic                out_valid_reg;
    logic [3:0]          out_index_reg;
    logic                out_active_reg;
    logic signed [12:0]  out_x_reg;
    logic                out_visible_reg;
    logic [15:0]         out_color_reg;
    logic                out_last_reg;

    rec_t                cur;
    rec_t                nxt;
    logic                unit_wen;
    logic                unit_visible;
    logic                accept;
    logic                advance;
    logic                line_we;
    logic                in_range;
    logic [4:0]          line_dec;

    assign cur      = lines_reg[idx_reg];
    assign accept   = items.valid && items.ready;
    assign in_range = (items.line >= 5'd1) && ({27'd0, items.line} <= 32'(LINES));
    assign line_dec = items.line - 5'd1;

    mlts_step_unit #(
        .PANEL_WIDTH (PANEL_WIDTH)
    ) u_step (
        .cur           (cur),
        .cmd           (cmd_reg),
        .default_color (default_color_reg),
        .nxt           (nxt),
        .wen           (unit_wen),
        .visible       (unit_visible)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (items.mode == MODE_TICK) ? ST_TICK : ST_CMD;
                end
            end
            ST_CMD:
            begin
                state_next = ST_IDLE;
            end
            ST_TICK:
            begin
                if (advance && (idx_reg == LAST_IDX))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        items.ready = 1'b0;
        advance     = 1'b0;
        line_we     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                items.ready = 1'b1;
            end
            ST_CMD:
            begin
                line_we = unit_wen;
            end
            ST_TICK:
            begin
                advance = !out_valid_reg || results.ready;
                line_we = advance && unit_wen;
            end
            default:
            begin
                items.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            idx_reg           <= '0;
            default_color_reg <= DEFAULT_COLOR_RESET;
            out_valid_reg     <= 1'b0;
            for (int i = 0; i < LINES; i++)
            begin
                lines_reg[i] <= '{active: 1'b0, direction: 1'b0, interval: INTERVAL_RESET,
                                  counter: 2'd0, x: PW13, width: 12'd0, color: 16'd0};
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                default_color_reg <= cfg_wdata;
            end
            if (accept)
            begin
                if (items.mode == MODE_TICK)
                begin
                    idx_reg <= '0;
                end
                else
                begin
                    idx_reg <= in_range ? line_dec[IDX_W-1:0] : '0;
                end
            end
            else if (advance)
            begin
                idx_reg <= (idx_reg == LAST_IDX) ? '0 : idx_reg + IDX_W'(1);
            end
            if (line_we)
            begin
                lines_reg[idx_reg] <= nxt;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= '{mode: items.mode, in_range: in_range, text_width: items.text_width,
                         speed: items.speed, direction: items.direction, color: items.color};
        end
        if (advance)
        begin
            out_index_reg   <= 4'(idx_reg);
            out_active_reg  <= nxt.active;
            out_x_reg       <= nxt.x;
            out_visible_reg <= unit_visible;
            out_color_reg   <= nxt.color;
            out_last_reg    <= (idx_reg == LAST_IDX);
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.line_index = out_index_reg;
    assign results.active     = out_active_reg;
    assign results.x_position = out_x_reg;
    assign results.visible    = out_visible_reg;
    assign results.line_color = out_color_reg;
    assign results.last       = out_last_reg;

    a_cmd_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMD) |=> (state_reg == ST_IDLE))
        else $error("command update took more than one cycle");

    a_tick_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (idx_reg == LAST_IDX)) |=> ((state_reg == ST_IDLE) && out_last_reg))
        else $error("tick walk did not end on the final line");

    a_report_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("line report lost");

    a_counter_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cur.counter != 2'd3))
        else $error("frame counter out of range");

    a_no_early_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (idx_reg != LAST_IDX)) |=> ((state_reg == ST_TICK) && !out_last_reg))
        else $error("last flag on an inner line");

endmodule

`default_nettype wire

// ===== hw/rtl/mlts_step_unit.sv =====
`default_nettype none

module mlts_step_unit
    import mlts_pkg::*;
#(
    parameter int PANEL_WIDTH = 64
) (
    input  var rec_t        cur,
    input  var cmd_t        cmd,
    input  wire [15:0]      default_color,
    output rec_t            nxt,
    output logic            wen,
    output logic            visible
);

    localparam logic signed [12:0] PW13 = 13'(PANEL_WIDTH);
    localparam logic signed [13:0] PW14 = 14'(PANEL_WIDTH);

    logic signed [13:0] x_wide;
    logic signed [13:0] w_wide;
    logic signed [13:0] x_dec;
    logic signed [13:0] x_inc;
    logic signed [13:0] dec_sum;
    logic signed [12:0] neg_cur_w;
    logic signed [12:0] neg_cmd_w;
    logic signed [12:0] step_x;
    logic [1:0]         cnt_inc;
    logic signed [13:0] nx_wide;
    logic signed [13:0] vis_sum;

    always_comb
    begin
        x_wide    = {cur.x[12], cur.x};
        w_wide    = $signed({2'b00, cur.width});
        x_dec     = x_wide - 14'sd1;
        x_inc     = x_wide + 14'sd1;
        dec_sum   = x_dec + w_wide;
        neg_cur_w = -$signed({1'b0, cur.width});
        neg_cmd_w = -$signed({1'b0, cmd.text_width});
        cnt_inc   = cur.counter + 2'd1;
        if (cur.direction == 1'b0)
        begin
            step_x = (dec_sum <= 14'sd0) ? PW13 : x_dec[12:0];
        end
        else
        begin
            step_x = (x_inc >= PW14) ? neg_cur_w : x_inc[12:0];
        end
    end

    always_comb
    begin
        nxt = cur;
        wen = 1'b0;
        unique case (cmd.mode)
            MODE_TICK:
            begin
                wen = 1'b1;
                if (cur.active)
                begin
                    if (cnt_inc < cur.interval)
                    begin
                        nxt.counter = cnt_inc;
                    end
                    else
                    begin
                        nxt.counter = 2'd0;
                        nxt.x       = step_x;
                    end
                end
            end
            MODE_LOAD:
            begin
                wen           = 1'b1;
                nxt.active    = 1'b1;
                nxt.counter   = 2'd0;
                nxt.color     = (cmd.color != 16'd0) ? cmd.color : default_color;
                nxt.direction = cmd.direction;
                nxt.interval  = speed_to_interval(cmd.speed);
                nxt.width     = cmd.text_width;
                nxt.x         = cmd.direction ? neg_cmd_w : PW13;
            end
            MODE_CLEAR:
            begin
                wen         = cmd.in_range;
                nxt.active  = 1'b0;
                nxt.width   = 12'd0;
                nxt.counter = 2'd0;
                nxt.x       = PW13;
            end
            MODE_SPEED:
            begin
                wen          = cmd.in_range && cur.active;
                nxt.interval = speed_to_interval(cmd.speed);
            end
            MODE_DIR:
            begin
                wen           = cmd.in_range && cur.active;
                nxt.direction = cmd.direction;
                nxt.x         = cmd.direction ? neg_cur_w : PW13;
            end
            MODE_COLOR:
            begin
                wen       = cmd.in_range && cur.active;
                nxt.color = cmd.color;
            end
            default:
            begin
                wen = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        nx_wide = {nxt.x[12], nxt.x};
        vis_sum = nx_wide + $signed({2'b00, nxt.width});
        visible = nxt.active && (nx_wide < PW14) && (vis_sum > 14'sd0);
    end

endmodule

`default_nettype wire

// ===== bench/tb_multi_line_text_scroll_engine_unit.sv =====
`default_nettype none

module tb_multi_line_text_scroll_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mlts_pkg::*;

    localparam int LINES        = 4;
    localparam int PANEL_WIDTH  = 64;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = LINES + 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int NUM_STEPS    = 25;

    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    typedef struct packed {
        logic [2:0]  mode;
        logic [4:0]  line;
        logic [11:0] text_width;
        logic [7:0]  speed;
        logic        direction;
        logic [15:0] color;
    } scroll_word_t;

    typedef struct packed {
        logic [3:0]         line_index;
        logic               active;
        logic signed [12:0] x_position;
        logic               visible;
        logic [15:0]        line_color;
        logic               last;
    } line_report_t;

    typedef struct packed {
        scroll_word_t       word;
        logic               typed;
        logic               t_active;
        logic signed [12:0] t_x;
        logic               t_visible;
        logic [15:0]        t_color;
    } step_row_t;

    // typed rows give the report of line index 0
    localparam step_row_t STEPS [NUM_STEPS] = '{
        '{'{MODE_TICK, 5'd0, 12'd0, 8'd0, 1'b0, 16'h0000}, 1'b1, 1'b0, 13'sd64, 1'b0, 16'h0000},
        '{'{MODE_LOAD, 5'd1, 12'd4095, 8'd3, 1'b0, 16'h0000}, 1'b0, 1'b0, 13'sd0, 1'b0, 16'h0000},
        '{'{MODE_TICK, 5'd0, 12'd0, 8'd0, 1'b0, 16'h0000}, 1'b1, 1'b1, 13'sd63, 1'b1, 16'hFFFF},
        '{'{MODE_DIR, 5'd1, 12'd0, 8'd0, 1'b1, 16'h0000}, 1'b0, 1'b0, 13'sd0, 1'b0, 16'h0000},
        '{'{MODE_TICK, 5'd0, 12'd0, 8'd0, 1'b0, 16'h0000}, 1'b1, 1'b1, -13'sd4094, 1'b1, 16'hFFFF},
        '{'{MODE_COLOR, 5'd1, 12'd0, 8'd0, 1'b0, 16'h0000}, 1'b0, 1'b0, 13'sd0, 1'b0, 16'h0000},
        '{'{MODE_TICK, 5'd0, 12'd0, 8'd0, 1'b0, 16'h0000}, 1'b1, 1'b1, -13'sd4093, 1'b1, 16'h0000},
        '{'{MODE_SPEED, 5'd1, 12'd0, 8'd1, 1'b0, 16'h0000}, 1'b0, 1'b0, 13'sd0, 1'b0, 16'h0000},
        '{'{MODE_LOAD, 5'd4, 12'd0, 8'd0, 1'b1, 16'h8001}, 1'b0, 1'b0, 13'sd0, 1'b0, 16'h0000},
        '{'{MODE_TICK, 5'd0, 12'd0, 8'd0, 1'b0, 16'h0000}, 1'b0, 1'b0, 13'sd0, 1'b0, 16'h0000},
        '{'{MODE_TICK, 5'd0, 12'd0, 8'd0, 1'b0, 16'h0000}, 1'b0, 1'b0, 13'sd0, 1'b0, 16'h0000},
        '{'{MODE_LOAD, 5'd0, 12'd1, 8'd2, 1'b0, 16'h0001}, 1'b0, 1'b0, 13'sd0, 1'b0, 16'h0000},
        '{'{MODE_TICK, 5'd0, 12'd0, 8'd0, 1'b0, 16'h0000}, 1'b1, 1'b1, 13'sd64, 1'b0, 16'h0001},
        '{'{MODE_TICK, 5'd0, 12'd0, 8'd0, 1'b0, 16'h0000}, 1'b0, 1'b0, 13'sd0, 1'b0, 16'h0000},
        '{'{MODE_SPEED, 5'd2, 12'd0, 8'd255, 1'b0, 16'h0000}, 1'b0, 1'b0, 13'sd0, 1'b0, 16'h0000},
        '{'{MODE_DIR, 5'd3, 12'd0, 8'd0, 1'b1, 16'h0000}, 1'b0, 1'b0, 13'sd0, 1'b0, 16'h0000},
        '{'{MODE_COLOR, 5'd2, 12'd0, 8'd0, 1'b0, 16'hFFFF}, 1'b0, 1'b0, 13'sd0, 1'b0, 16'h0000},
        '{'{MODE_CLEAR, 5'd5, 12'd0, 8'd0, 1'b0, 16'h0000}, 1'b0, 1'b0, 13'sd0, 1'b0, 16'h0000},
        '{'{MODE_SPARE6, 5'd1, 12'd4095, 8'd255, 1'b1, 16'hFFFF}, 1'b0, 1'b0, 13'sd0, 1'b0, 16'h0000},
        '{'{MODE_SPARE7, 5'd31, 12'd4095, 8'd255, 1'b1, 16'hFFFF}, 1'b0, 1'b0, 13'sd0, 1'b0, 16'h0000},
        '{'{MODE_LOAD, 5'd31, 12'd8, 8'd3, 1'b0, 16'hFFFF}, 1'b0, 1'b0, 13'sd0, 1'b0, 16'h0000},
        '{'{MODE_CLEAR, 5'd1, 12'd0, 8'd0, 1'b0, 16'h0000}, 1'b0, 1'b0, 13'sd0, 1'b0, 16'h0000},
        '{'{MODE_TICK, 5'd0, 12'd0, 8'd0, 1'b0, 16'h0000}, 1'b1, 1'b0, 13'sd64, 1'b0, 16'hFFFF},
        '{'{MODE_COLOR, 5'd16, 12'd0, 8'd0, 1'b0, 16'h1234}, 1'b0, 1'b0, 13'sd0, 1'b0, 16'h0000},
        '{'{MODE_TICK, 5'd0, 12'd0, 8'd0, 1'b0, 16'h0000}, 1'b0, 1'b0, 13'sd0, 1'b0, 16'h0000}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    bit          idle_on;
    int          phase_no;
    int          errors;

    mlts_in_if  items_if ();
    mlts_out_if results_if ();

    multi_line_text_scroll_engine_unit #(
        .LINES      (LINES),
        .PANEL_WIDTH(PANEL_WIDTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .items    (items_if),
        .results  (results_if)
    );

    // line table as the block should hold it
    logic         ln_active   [LINES];
    logic         ln_dir      [LINES];
    logic [1:0]   ln_interval [LINES];
    logic [1:0]   ln_count    [LINES];
    int           ln_x        [LINES];
    int           ln_width    [LINES];
    logic [15:0]  ln_color    [LINES];
    logic [15:0]  dflt_color;
    line_report_t reports_due [$];

    function automatic logic [1:0] frame_interval(input logic [7:0] speed);
        logic [1:0] iv;
        case (speed)
            8'd1:    iv = 2'd3;
            8'd3:    iv = 2'd1;
            default: iv = 2'd2;
        endcase
        return iv;
    endfunction

    function automatic int home_x(input int i);
        return ln_dir[i] ? -ln_width[i] : PANEL_WIDTH;
    endfunction

    task automatic reset_scroll_table();
        dflt_color = DEFAULT_COLOR_RESET;
        for (int i = 0; i < LINES; i++)
        begin
            ln_active[i]   = 1'b0;
            ln_dir[i]      = 1'b0;
            ln_interval[i] = INTERVAL_RESET;
            ln_count[i]    = 2'd0;
            ln_x[i]        = PANEL_WIDTH;
            ln_width[i]    = 0;
            ln_color[i]    = 16'h0000;
        end
    endtask

    task automatic scroll_table_step(input scroll_word_t w);
        bit           in_range;
        int           idx;
        line_report_t rep;
        in_range = (w.line >= 5'd1) && (w.line <= 5'(LINES));
        idx = in_range ? int'(w.line) - 1 : 0;
        case (w.mode)
            MODE_TICK:
            begin
                for (int i = 0; i < LINES; i++)
                begin
                    if (ln_active[i])
                    begin
                        ln_count[i] = ln_count[i] + 2'd1;
                        if (ln_count[i] >= ln_interval[i])
                        begin
                            ln_count[i] = 2'd0;
                            if (!ln_dir[i])
                            begin
                                ln_x[i] = ln_x[i] - 1;
                                if (ln_x[i] + ln_width[i] <= 0) ln_x[i] = PANEL_WIDTH;
                            end
                            else
                            begin
                                ln_x[i] = ln_x[i] + 1;
                                if (ln_x[i] >= PANEL_WIDTH) ln_x[i] = -ln_width[i];
                            end
                        end
                    end
                end
                for (int i = 0; i < LINES; i++)
                begin
                    rep.line_index = 4'(i);
                    rep.active     = ln_active[i];
                    rep.x_position = 13'(ln_x[i]);
                    rep.visible    = ln_active[i] && (ln_x[i] < PANEL_WIDTH)
                                     && (ln_x[i] + ln_width[i] > 0);
                    rep.line_color = ln_color[i];
                    rep.last       = (i == LINES - 1);
                    reports_due.push_back(rep);
                end
            end
            MODE_LOAD:
            begin
                ln_count[idx]    = 2'd0;
                ln_color[idx]    = (w.color != 16'h0000) ? w.color : dflt_color;
                ln_dir[idx]      = w.direction;
                ln_interval[idx] = frame_interval(w.speed);
                ln_width[idx]    = int'(w.text_width);
                ln_x[idx]        = home_x(idx);
                ln_active[idx]   = 1'b1;
            end
            MODE_CLEAR:
            begin
                if (in_range)
                begin
                    ln_active[idx] = 1'b0;
                    ln_width[idx]  = 0;
                    ln_count[idx]  = 2'd0;
                    ln_x[idx]      = PANEL_WIDTH;
                end
            end
            MODE_SPEED:
            begin
                if (in_range && ln_active[idx]) ln_interval[idx] = frame_interval(w.speed);
            end
            MODE_DIR:
            begin
                if (in_range && ln_active[idx])
                begin
                    ln_dir[idx] = w.direction;
                    ln_x[idx]   = home_x(idx);
                end
            end
            MODE_COLOR:
            begin
                if (in_range && ln_active[idx]) ln_color[idx] = w.color;
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic signed [31:0] e,
                               input logic signed [31:0] a);
        if (e !== a)
        begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, e, a);
        end
    endtask

    task automatic check_report();
        line_report_t exp_rep;
        if (reports_due.size() == 0)
        begin
            errors++;
            $display("%0t: word with none expected, expected nothing actual line_index %0d",
                     $time, results_if.line_index);
        end
        else
        begin
            exp_rep = reports_due.pop_front();
            check_field("line_index", exp_rep.line_index, results_if.line_index);
            check_field("active", exp_rep.active, results_if.active);
            check_field("x_position", exp_rep.x_position, results_if.x_position);
            check_field("visible", exp_rep.visible, results_if.visible);
            check_field("line_color", exp_rep.line_color, results_if.line_color);
            check_field("last", exp_rep.last, results_if.last);
        end
    endtask

    function automatic scroll_word_t random_word(input logic [2:0] mode);
        scroll_word_t w;
        w.mode = mode;
        w.line = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                              : 5'($urandom_range(1, LINES));
        case ($urandom_range(0, 9))
            7:       w.text_width = 12'($urandom_range(0, 4095));
            8:       w.text_width = 12'hFFF;
            9:       w.text_width = 12'h000;
            default: w.text_width = 12'($urandom_range(0, 15));
        endcase
        w.speed = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, 3))
                                             : 8'($urandom_range(0, 255));
        w.direction = 1'($urandom_range(0, 1));
        w.color = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom_range(0, 65535));
        return w;
    endfunction

    task automatic push_word(input scroll_word_t w);
        items_if.valid      <= 1'b1;
        items_if.mode       <= w.mode;
        items_if.line       <= w.line;
        items_if.text_width <= w.text_width;
        items_if.speed      <= w.speed;
        items_if.direction  <= w.direction;
        items_if.color      <= w.color;
        do @(posedge clk); while (!items_if.ready);
        scroll_table_step(w);
    endtask

    task automatic maybe_gap(input bit quiet);
        if (idle_on && !quiet && $urandom_range(0, 3) == 0)
        begin
            items_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic settle();
        items_if.valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_default(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        dflt_color = value;
    endtask

    // loads followed by a run of ticks mixed with other commands
    task automatic run_random_phase(input int n_items);
        int           sent;
        int           run_len;
        int           pick;
        bit           quiet;
        scroll_word_t w;
        sent = 0;
        while (sent < n_items)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, LINES))
            begin
                if (sent < n_items)
                begin
                    w = random_word(MODE_LOAD);
                    push_word(w);
                    maybe_gap(quiet);
                    sent++;
                end
            end
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(70, 140)
                                                  : $urandom_range(1, 20);
            if (run_len > n_items - sent) run_len = n_items - sent;
            repeat (run_len)
            begin
                pick = $urandom_range(0, 19);
                case (pick)
                    14: w = random_word(MODE_SPEED);
                    15: w = random_word(MODE_DIR);
                    16: w = random_word(MODE_COLOR);
                    17: w = random_word(MODE_CLEAR);
                    18: w = random_word(MODE_LOAD);
                    19:
                    begin
                        w = random_word(3'($urandom_range(0, 7)));
                        w.line = 5'($urandom_range(0, 31));
                    end
                    default: w = random_word(MODE_TICK);
                endcase
                push_word(w);
                maybe_gap(quiet);
                sent++;
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        int cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("multi_line_text_scroll_engine_unit: mismatch");
        $finish;
    end

    // result side: check each accepted report, then pick next ready
    initial
    begin
        int stall_left;
        int hold_left;
        bit calm;
        bit hold_done;
        results_if.ready = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        calm       = 1'b0;
        hold_done  = 1'b0;
        do @(posedge clk); while (rst_n !== 1'b1);
        forever
        begin
            @(posedge clk);
            if (results_if.valid && results_if.ready) check_report();
            if (!hold_done && phase_no == 1)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if ($urandom_range(0, 63) == 0) calm = !calm;
            if (hold_left > 0)
            begin
                hold_left--;
                results_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                results_if.ready <= 1'b0;
            end
            else if (idle_on && !calm && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 4) - 1;
                results_if.ready <= 1'b0;
            end
            else
            begin
                results_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int k;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = 16'h0000;
        items_if.valid      = 1'b0;
        items_if.mode       = MODE_TICK;
        items_if.line       = 5'd0;
        items_if.text_width = 12'd0;
        items_if.speed      = 8'd0;
        items_if.direction  = 1'b0;
        items_if.color      = 16'h0000;
        idle_on             = 1'b1;
        phase_no            = 0;
        errors              = 0;
        reset_scroll_table();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_default(DEFAULT_COLOR_RESET);

        for (int s = 0; s < NUM_STEPS; s++)
        begin
            push_word(STEPS[s].word);
            if (STEPS[s].typed)
            begin
                k = reports_due.size() - LINES;
                reports_due[k].active     = STEPS[s].t_active;
                reports_due[k].x_position = STEPS[s].t_x;
                reports_due[k].visible    = STEPS[s].t_visible;
                reports_due[k].line_color = STEPS[s].t_color;
            end
            maybe_gap(1'b0);
        end
        settle();

        phase_no = 1;
        write_default(16'h0000);
        run_random_phase(100);
        settle();

        phase_no = 2;
        write_default(16'($urandom_range(0, 65535)));
        run_random_phase(100);
        settle();

        phase_no = 3;
        write_default(16'hFFFF);
        run_random_phase(100);
        settle();

        // closing stretch at full rate on both sides
        phase_no = 4;
        idle_on  = 1'b0;
        write_default(16'h07E0);
        run_random_phase(60);
        settle();

        if (errors == 0)
            $display("multi_line_text_scroll_engine_unit: match");
        else
            $display("multi_line_text_scroll_engine_unit: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
